[hw/rtl/chipset_memory_route_decoder_unit_defines.svh]
// Assertion macros shared by the memory route decoder RTL.
`ifndef CHIPSET_MEMORY_ROUTE_DECODER_UNIT_DEFINES_SVH
`define CHIPSET_MEMORY_ROUTE_DECODER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CMRD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CMRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CMRD_ASSERT_IMPL(label, ante, cons)
`define CMRD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/cmrd_pkg.sv]
// Types and constants for the memory route decoder.
package cmrd_pkg;

    localparam int MapEntriesDefault = 64;

    typedef enum logic [1:0] {
        TGT_RAM  = 2'd0,
        TGT_EXT  = 2'd1,
        TGT_FW   = 2'd2,
        TGT_OPEN = 2'd3
    } t_target;

    localparam logic KIND_RESOLVE   = 1'b0;
    localparam logic KIND_MAP_WRITE = 1'b1;

    localparam logic [1:0] REG_CONTROL   = 2'd0;
    localparam logic [1:0] REG_BANK_SIZE = 2'd1;
    localparam logic [1:0] REG_BANKS     = 2'd2;

    localparam logic [7:0] CONTROL_RESET = 8'd0;
    localparam logic       BANK_SIZE_RESET = 1'b0;
    localparam logic [2:0] BANKS_RESET   = 3'd1;

    typedef struct packed {
        logic        kind;
        logic [23:0] address;
        logic        is_cpu;
        logic        a20_enabled;
        logic [5:0]  map_index;
        logic [9:0]  map_value;
    } t_cmrd_in;

    typedef struct packed {
        logic        status;
        t_target     target;
        logic [23:0] offset;
        logic        writable;
        logic [14:0] page_span;
    } t_cmrd_out;

endpackage

[hw/rtl/chipset_memory_route_decoder_unit.sv]
// Memory route decoder: mapping register store, address route logic and APB registers.
// A transfer accepted at an edge is held in the stage-one registers, and its result is
// registered and strobed from the second stage. One transfer is taken every cycle and busy
// stays low; the mapping table read and its registered output set this two-stage pipeline.
// Reset restores the configuration registers and clears the table valid bits, so every
// mapping register reads as zero until written; there is no clearing pass.
`include "chipset_memory_route_decoder_unit_defines.svh"
module chipset_memory_route_decoder_unit #(
    parameter int MAP_ENTRIES = cmrd_pkg::MapEntriesDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  cmrd_pkg::t_cmrd_in  i_cmd,
    output logic                o_result_stb,
    output cmrd_pkg::t_cmrd_out o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import cmrd_pkg::*;

    localparam int IdxW = $clog2(MAP_ENTRIES);

    logic [7:0]      r_cr;
    logic            r_bsl;
    logic [2:0]      r_banks;
    logic [9:0]      r_mem [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] r_vld;

    logic            r_s1_vld;
    logic            r_s1_kind;
    logic [23:0]     r_s1_addr;
    logic            r_s1_hit;
    logic [9:0]      r_map_rd;
    logic            r_map_vld;

    logic            r_res_stb;
    t_cmrd_out       r_res;

    logic            accept;
    logic            cfg_wr;
    logic [23:0]     a0;
    logic            win_lo;
    logic            win_hi;
    logic [5:0]      slot0;
    logic [IdxW-1:0] rd_idx;
    logic [IdxW-1:0] wr_idx;

    logic [23:0]     a;
    logic [14:0]     contig;
    logic [2:0]      sel_cnt;
    logic [23:0]     selected;
    logic [23:0]     top;
    logic [23:0]     ram;
    logic            fw;
    logic            shadow;
    logic [9:0]      entry;
    logic            slot_en;
    logic [23:0]     off;
    logic [23:0]     avail;
    t_cmrd_out       n_res;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_CONTROL:   prdata = {24'd0, r_cr};
            REG_BANK_SIZE: prdata = {31'd0, r_bsl};
            REG_BANKS:     prdata = {29'd0, r_banks};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        a0 = i_cmd.address;
        if (i_cmd.is_cpu && !i_cmd.a20_enabled) begin
            a0[20] = 1'b0;
        end
        win_lo = (a0 >= 24'h040000) && (a0 < 24'h0a0000);
        win_hi = (a0 >= 24'h0c0000) && (a0 < 24'h0e0000);
        slot0  = win_lo ? (a0[19:14] - 6'd16) : (a0[19:14] - 6'd24);
        rd_idx = IdxW'({r_cr[0], slot0[4:0]});
        wr_idx = i_cmd.map_index[IdxW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd.kind == KIND_MAP_WRITE) begin
            r_mem[wr_idx] <= i_cmd.map_value;
        end
        if (accept) begin
            r_map_rd  <= r_mem[rd_idx];
            r_s1_kind <= i_cmd.kind;
            r_s1_addr <= a0;
            r_s1_hit  <= r_cr[1] && (win_lo || win_hi);
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr      <= CONTROL_RESET;
            r_bsl     <= BANK_SIZE_RESET;
            r_banks   <= BANKS_RESET;
            r_vld     <= '0;
            r_s1_vld  <= 1'b0;
            r_map_vld <= 1'b0;
            r_res_stb <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_CONTROL:   r_cr    <= pwdata[7:0];
                    REG_BANK_SIZE: r_bsl   <= pwdata[0];
                    REG_BANKS:     r_banks <= pwdata[2:0];
                    default:       ;
                endcase
            end
            if (accept && i_cmd.kind == KIND_MAP_WRITE) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (accept) begin
                r_map_vld <= r_vld[rd_idx];
            end
            r_s1_vld  <= accept;
            r_res_stb <= r_s1_vld;
        end
    end

    always_comb begin
        a        = r_s1_addr;
        contig   = 15'h4000 - {1'b0, a[13:0]};
        sel_cnt  = {1'b0, r_cr[6:5]} + 3'd1;
        selected = r_cr[7] ? {sel_cnt, 21'd0} : {2'd0, sel_cnt, 19'd0};
        top      = selected + (r_cr[2] ? 24'd0 : 24'h060000);
        ram      = r_bsl ? {r_banks, 21'd0} : {2'd0, r_banks, 19'd0};
        fw       = ((a >= 24'h0e0000) && (a <= 24'h0fffff)) || (a >= 24'hfe0000);
        shadow   = fw && r_cr[2] && (a[16] ? r_cr[4] : r_cr[3]);
        entry    = r_map_vld ? r_map_rd : 10'd0;
        slot_en  = r_s1_hit && entry[9];

        if (fw) begin
            off = {4'd0, a[19:0] ^ 20'h10000};
        end else if (slot_en) begin
            if (r_cr[7]) begin
                off = {1'b0, entry[8:7], entry[6:5], entry[4:0], a[13:0]};
            end else begin
                off = {3'd0, entry[8:7], entry[4:0], a[13:0]};
            end
        end else if ((a >= 24'h100000) && !r_cr[2]) begin
            off = a - 24'h060000;
        end else begin
            off = a;
        end
        avail = ram - off;

        n_res = '0;
        priority if (r_s1_kind == KIND_MAP_WRITE) begin
            n_res = '0;
        end else if (fw && !shadow) begin
            n_res.target    = TGT_FW;
            n_res.offset    = {7'd0, a[16:0]};
            n_res.page_span = contig;
        end else if (!fw && !slot_en && (a < 24'h0a0000) && (selected < 24'h100000)) begin
            n_res.status = 1'b1;
        end else if (!fw && !slot_en && (a >= 24'h0a0000)
                     && !((a >= 24'h100000) && (a < top))) begin
            n_res.target    = TGT_EXT;
            n_res.offset    = a;
            n_res.writable  = 1'b1;
            n_res.page_span = contig;
        end else if (r_cr[7] != r_bsl) begin
            n_res.status = 1'b1;
        end else if (off < ram) begin
            n_res.target    = TGT_RAM;
            n_res.offset    = off;
            n_res.writable  = !shadow;
            n_res.page_span = (avail < {9'd0, contig}) ? avail[14:0] : contig;
        end else begin
            n_res.target    = TGT_OPEN;
            n_res.page_span = contig;
        end
    end

    assign o_result_stb = r_res_stb;
    assign o_result     = r_res;

    `CMRD_ASSERT_NEXT(a_accept_to_stage, accept, r_s1_vld)
    `CMRD_ASSERT_NEXT(a_stage_to_strobe, r_s1_vld, o_result_stb)
    `CMRD_ASSERT_NEXT(a_map_write_zero, r_s1_vld && r_s1_kind == KIND_MAP_WRITE, o_result == '0)
    `CMRD_ASSERT_IMPL(a_unsupported_zero, o_result_stb && o_result.status, o_result.target == TGT_RAM && o_result.offset == 24'd0 && !o_result.writable && o_result.page_span == 15'd0)
    `CMRD_ASSERT_IMPL(a_open_bus_clean, o_result_stb && o_result.target == TGT_OPEN, o_result.offset == 24'd0 && !o_result.writable)

endmodule
